FILE: rtl/msid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msid_pkg
// shared types and codes for the instruction decoder
// ----------------------------------------------------------------------------
package msid_pkg;

    // major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_NORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_HALT    = 6'd63;

    // function codes under OP_SPECIAL
    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_SRA  = 6'd3;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_XOR  = 6'd38;
    localparam logic [5:0] FN_NOR  = 6'd39;
    localparam logic [5:0] FN_NAND = 6'd40;
    localparam logic [5:0] FN_SLT  = 6'd42;

    typedef enum logic [1:0] {
        CLS_R = 2'd0,
        CLS_I = 2'd1,
        CLS_J = 2'd2,
        CLS_S = 2'd3
    } t_class;

    typedef enum logic [5:0] {
        MN_NOP     = 6'd0,
        MN_ADD     = 6'd1,
        MN_ADDU    = 6'd2,
        MN_SUB     = 6'd3,
        MN_AND     = 6'd4,
        MN_OR      = 6'd5,
        MN_XOR     = 6'd6,
        MN_NOR     = 6'd7,
        MN_NAND    = 6'd8,
        MN_SLT     = 6'd9,
        MN_SLL     = 6'd10,
        MN_SRL     = 6'd11,
        MN_SRA     = 6'd12,
        MN_JR      = 6'd13,
        MN_J       = 6'd14,
        MN_JAL     = 6'd15,
        MN_HALT    = 6'd16,
        MN_ADDI    = 6'd17,
        MN_ADDIU   = 6'd18,
        MN_LW      = 6'd19,
        MN_LH      = 6'd20,
        MN_LHU     = 6'd21,
        MN_LB      = 6'd22,
        MN_LBU     = 6'd23,
        MN_SW      = 6'd24,
        MN_SH      = 6'd25,
        MN_SB      = 6'd26,
        MN_LUI     = 6'd27,
        MN_ANDI    = 6'd28,
        MN_ORI     = 6'd29,
        MN_NORI    = 6'd30,
        MN_SLTI    = 6'd31,
        MN_BEQ     = 6'd32,
        MN_BNE     = 6'd33,
        MN_BGTZ    = 6'd34,
        MN_UNKNOWN = 6'd35
    } t_mnem;

    // one decoded instruction
    typedef struct packed {
        logic [5:0]  opcode;
        logic [4:0]  src_reg;
        logic [4:0]  tgt_reg;
        logic [4:0]  dst_reg;
        logic [4:0]  shift_amount;
        logic [5:0]  func_code;
        logic [31:0] imm_value;
        logic [25:0] jump_target;
        t_class      instr_class;
        t_mnem       mnemonic;
        logic        reads_rs;
        logic        reads_rt;
    } t_dec_result;

endpackage

FILE: rtl/msid_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msid_decode
// combinational field split, class and mnemonic lookup for one word
// ----------------------------------------------------------------------------
module msid_decode (
    input  logic [31:0]          i_word,
    output msid_pkg::t_dec_result o_dec
);

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [5:0]  fn;
    logic [15:0] imm16;
    logic        is_shift;

    assign op       = i_word[31:26];
    assign rs       = i_word[25:21];
    assign rt       = i_word[20:16];
    assign rd       = i_word[15:11];
    assign sh       = i_word[10:6];
    assign fn       = i_word[5:0];
    assign imm16    = i_word[15:0];
    assign is_shift = (fn == msid_pkg::FN_SLL) || (fn == msid_pkg::FN_SRL)
                   || (fn == msid_pkg::FN_SRA);

    always_comb begin
        o_dec              = '0;
        o_dec.opcode       = op;
        o_dec.instr_class  = msid_pkg::CLS_R;
        o_dec.mnemonic     = msid_pkg::MN_UNKNOWN;

        priority if (op == msid_pkg::OP_SPECIAL) begin
            o_dec.instr_class = msid_pkg::CLS_R;
            o_dec.func_code   = fn;
            if (!is_shift) o_dec.src_reg = rs;
            if (fn != msid_pkg::FN_JR) begin
                o_dec.tgt_reg = rt;
                o_dec.dst_reg = rd;
            end
            if (is_shift) o_dec.shift_amount = sh;
            unique case (fn)
                msid_pkg::FN_ADD: begin
                    o_dec.mnemonic = msid_pkg::MN_ADD;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_ADDU: begin
                    o_dec.mnemonic = msid_pkg::MN_ADDU;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_SUB: begin
                    o_dec.mnemonic = msid_pkg::MN_SUB;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_AND: begin
                    o_dec.mnemonic = msid_pkg::MN_AND;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_OR: begin
                    o_dec.mnemonic = msid_pkg::MN_OR;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_XOR: begin
                    o_dec.mnemonic = msid_pkg::MN_XOR;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_NOR: begin
                    o_dec.mnemonic = msid_pkg::MN_NOR;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_NAND: begin
                    o_dec.mnemonic = msid_pkg::MN_NAND;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_SLT: begin
                    o_dec.mnemonic = msid_pkg::MN_SLT;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_SLL: begin
                    o_dec.mnemonic = msid_pkg::MN_SLL;
                    o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_SRL: begin
                    o_dec.mnemonic = msid_pkg::MN_SRL;
                    o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_SRA: begin
                    o_dec.mnemonic = msid_pkg::MN_SRA;
                    o_dec.reads_rt = 1'b1;
                end
                msid_pkg::FN_JR: begin
                    o_dec.mnemonic = msid_pkg::MN_JR;
                    o_dec.reads_rs = 1'b1;
                end
                default: o_dec.mnemonic = msid_pkg::MN_UNKNOWN;
            endcase
        end else if ((op == msid_pkg::OP_J) || (op == msid_pkg::OP_JAL)) begin
            o_dec.instr_class = msid_pkg::CLS_J;
            o_dec.jump_target = i_word[25:0];
            o_dec.mnemonic    = (op == msid_pkg::OP_J) ? msid_pkg::MN_J
                                                       : msid_pkg::MN_JAL;
        end else if (op == msid_pkg::OP_HALT) begin
            o_dec.instr_class = msid_pkg::CLS_S;
            o_dec.mnemonic    = msid_pkg::MN_HALT;
        end else begin
            o_dec.instr_class = msid_pkg::CLS_I;
            o_dec.src_reg     = rs;
            o_dec.tgt_reg     = rt;
            o_dec.imm_value   = {{16{imm16[15]}}, imm16};
            unique case (op)
                msid_pkg::OP_ADDI: begin
                    o_dec.mnemonic = msid_pkg::MN_ADDI;  o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_ADDIU: begin
                    o_dec.mnemonic = msid_pkg::MN_ADDIU; o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_LW: begin
                    o_dec.mnemonic = msid_pkg::MN_LW;    o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_LH: begin
                    o_dec.mnemonic = msid_pkg::MN_LH;    o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_LHU: begin
                    o_dec.mnemonic = msid_pkg::MN_LHU;   o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_LB: begin
                    o_dec.mnemonic = msid_pkg::MN_LB;    o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_LBU: begin
                    o_dec.mnemonic = msid_pkg::MN_LBU;   o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_SW: begin
                    o_dec.mnemonic = msid_pkg::MN_SW;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::OP_SH: begin
                    o_dec.mnemonic = msid_pkg::MN_SH;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::OP_SB: begin
                    o_dec.mnemonic = msid_pkg::MN_SB;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::OP_LUI: begin
                    o_dec.mnemonic = msid_pkg::MN_LUI;
                end
                msid_pkg::OP_ANDI: begin
                    o_dec.mnemonic  = msid_pkg::MN_ANDI; o_dec.reads_rs = 1'b1;
                    o_dec.imm_value = {16'd0, imm16};
                end
                msid_pkg::OP_ORI: begin
                    o_dec.mnemonic  = msid_pkg::MN_ORI;  o_dec.reads_rs = 1'b1;
                    o_dec.imm_value = {16'd0, imm16};
                end
                msid_pkg::OP_NORI: begin
                    o_dec.mnemonic  = msid_pkg::MN_NORI; o_dec.reads_rs = 1'b1;
                    o_dec.imm_value = {16'd0, imm16};
                end
                msid_pkg::OP_SLTI: begin
                    o_dec.mnemonic = msid_pkg::MN_SLTI;  o_dec.reads_rs = 1'b1;
                end
                msid_pkg::OP_BEQ: begin
                    o_dec.mnemonic = msid_pkg::MN_BEQ;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::OP_BNE: begin
                    o_dec.mnemonic = msid_pkg::MN_BNE;
                    o_dec.reads_rs = 1'b1; o_dec.reads_rt = 1'b1;
                end
                msid_pkg::OP_BGTZ: begin
                    o_dec.mnemonic = msid_pkg::MN_BGTZ;  o_dec.reads_rs = 1'b1;
                end
                default: o_dec.mnemonic = msid_pkg::MN_UNKNOWN;
            endcase
        end

        // all-zero word is reported as nop, other fields as for sll
        if (i_word == 32'd0) o_dec.mnemonic = msid_pkg::MN_NOP;
    end

endmodule

FILE: rtl/mips_subset_instruction_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_instruction_decoder_unit
// splits a 32-bit instruction word into fields, class, mnemonic and read flags
// ----------------------------------------------------------------------------
// usage
//   request channel: drive i_instr_word and pulse i_start; a request is taken
//   at any rising edge with i_start high and o_busy low
//   o_busy stays low: a new request can be taken on every cycle
//   result channel: o_valid is high for exactly one cycle with all result
//   ports holding the decoded fields of one request, in request order
// pipeline and throughput
//   the word is captured in an input register, decoded by one level of
//   combinational logic and captured in the result register, with o_valid
//   registered alongside it; one result per cycle sustained
// reset
//   i_rst_n low at a rising edge drops both pipeline valid bits, so requests
//   in flight are discarded and no strobe comes out of reset
// stall
//   the receiver cannot hold results off; each result shows for one cycle
// ----------------------------------------------------------------------------
module mips_subset_instruction_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    output logic [5:0]  o_opcode,
    output logic [4:0]  o_src_reg,
    output logic [4:0]  o_tgt_reg,
    output logic [4:0]  o_dst_reg,
    output logic [4:0]  o_shift_amount,
    output logic [5:0]  o_func_code,
    output logic [31:0] o_imm_value,
    output logic [25:0] o_jump_target,
    output logic [1:0]  o_instr_class,
    output logic [5:0]  o_mnemonic,
    output logic        o_reads_rs,
    output logic        o_reads_rt
);

    // input stage
    logic                  r_in_valid;
    logic [31:0]           r_in_word;
    // result stage
    logic                  r_out_valid;
    msid_pkg::t_dec_result r_out;
    msid_pkg::t_dec_result n_out;
    logic                  req_take;

    // single-pass pipeline, never back-pressured
    assign o_busy   = 1'b0;
    assign req_take = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= req_take;
            r_out_valid <= r_in_valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (req_take) r_in_word <= i_instr_word;
        if (r_in_valid) r_out <= n_out;
    end

    msid_decode u_decode (
        .i_word (r_in_word),
        .o_dec  (n_out)
    );

    assign o_valid        = r_out_valid;
    assign o_opcode       = r_out.opcode;
    assign o_src_reg      = r_out.src_reg;
    assign o_tgt_reg      = r_out.tgt_reg;
    assign o_dst_reg      = r_out.dst_reg;
    assign o_shift_amount = r_out.shift_amount;
    assign o_func_code    = r_out.func_code;
    assign o_imm_value    = r_out.imm_value;
    assign o_jump_target  = r_out.jump_target;
    assign o_instr_class  = r_out.instr_class;
    assign o_mnemonic     = r_out.mnemonic;
    assign o_reads_rs     = r_out.reads_rs;
    assign o_reads_rt     = r_out.reads_rt;

endmodule
